// ===== rtl/core/assert_macros.svh =====
// assertion macros for the keypad scanner rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KPS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("keypad scanner assertion failed");
`define KPS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("keypad scanner forbidden condition seen");
`else
`define KPS_ASSERT(lbl, clk, rst_n, prop)
`define KPS_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== rtl/core/kps_pkg.sv =====
// types, constants and the column decode for the keypad scanner
`default_nettype none
package kps_pkg;

	localparam int CNT_W   = 16;
	localparam int COLS    = 4;
	localparam int MASK_W  = 9;
	localparam int CODE_W  = 4;
	localparam int DRIVE_W = 2;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 2;

	localparam logic [CNT_W-1:0] SETTLE_RESET = 16'h1000;
	localparam logic [CNT_W-1:0] STABLE_RESET = 16'd500;

	localparam logic [IDX_W-1:0] CFG_SETTLE_TICKS   = 2'd0;
	localparam logic [IDX_W-1:0] CFG_STABLE_SAMPLES = 2'd1;
	localparam logic [IDX_W-1:0] CFG_SCAN_MODE      = 2'd2;

	localparam logic [DRIVE_W-1:0] DRIVE_BOTH = 2'b11;
	localparam logic [DRIVE_W-1:0] DRIVE_ROW1 = 2'b10;
	localparam logic [DRIVE_W-1:0] DRIVE_ROW0 = 2'b01;

	localparam logic [CODE_W-1:0] CODE_NONE = 4'd0;
	localparam logic [CODE_W-1:0] CODE_PUSH = 4'd9;
	localparam logic [CODE_W-1:0] ROW1_OFFSET = 4'd4;

	localparam logic MODE_SINGLE = 1'b0;

	typedef struct packed {
		logic [COLS-1:0] column_pins_n;
		logic            push_pin_n;
	} kps_in_t;

	typedef struct packed {
		logic [DRIVE_W-1:0] row_drive;
		logic               scan_done;
		logic [CODE_W-1:0]  key_code;
		logic [MASK_W-1:0]  key_mask;
	} kps_out_t;

	// key number for exactly one pressed column, 0 otherwise
	function automatic logic [2:0] col_code(input logic [COLS-1:0] pressed);
		logic [2:0] c;
		case (pressed)
			4'b0001: c = 3'd1;
			4'b0010: c = 3'd2;
			4'b0100: c = 3'd3;
			4'b1000: c = 3'd4;
			default: c = 3'd0;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/kps_in_if.sv =====
// pin sample channel of the keypad scanner
`default_nettype none
interface kps_in_if;
	logic       valid;
	logic       ready;
	logic [3:0] column_pins_n;
	logic       push_pin_n;

	modport source (output valid, output column_pins_n, output push_pin_n, input ready);
	modport sink (input valid, input column_pins_n, input push_pin_n, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/kps_out_if.sv =====
// result channel of the keypad scanner
`default_nettype none
interface kps_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] row_drive;
	logic       scan_done;
	logic [3:0] key_code;
	logic [8:0] key_mask;

	modport source (output valid, output row_drive, output scan_done, output key_code,
		output key_mask, input ready);
	modport sink (input valid, input row_drive, input scan_done, input key_code,
		input key_mask, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/keypad_scan_debounce.sv =====
// keypad scanner top level: debounce, row scan and result queue
// One pin sample is taken per item and every item yields one result item.
// An item is registered on entry, the scan step is worked out from that
// register and the scan state, and the result goes into a two-entry output
// queue; one item is accepted in every cycle while results drain. Each
// result passes the input register and then the queue head. Items are
// accepted while a result waits, until the output queue is full.
// Configuration writes take effect at once and are meant for idle periods.
`default_nettype none
`include "assert_macros.svh"
module keypad_scan_debounce
	import kps_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cfg_we,
	input  wire [IDX_W-1:0]  cfg_index,
	input  wire [CFG_W-1:0]  cfg_data,
	kps_in_if.sink           keys,
	kps_out_if.source        result
);

	typedef enum logic [1:0] {
		PH_ALL_SETTLE  = 2'd0,
		PH_STABLE      = 2'd1,
		PH_ROW1_SETTLE = 2'd2,
		PH_ROW0_SETTLE = 2'd3
	} phase_t;

	logic [CNT_W-1:0] settle_q;
	logic [CNT_W-1:0] stable_q;
	logic             mode_q;

	phase_t           phase_q, phase_n;
	logic [CNT_W-1:0] cnt_q, cnt_n, cnt_inc;
	logic [4:0]       ref_q, ref_n;
	logic [COLS-1:0]  part_q, part_n;

	logic    item_v_s1;
	kps_in_t item_s1;

	logic     head_v_q, skid_v_q;
	kps_out_t head_q, skid_q;

	logic     adv, pop, in_ready;
	kps_out_t res;

	logic [COLS-1:0] pressed;
	logic [4:0]      sample;
	logic [2:0]      col;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_RESET;
			stable_q <= STABLE_RESET;
			mode_q   <= MODE_SINGLE;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SETTLE_TICKS:   settle_q <= cfg_data[CNT_W-1:0];
				CFG_STABLE_SAMPLES: stable_q <= cfg_data[CNT_W-1:0];
				CFG_SCAN_MODE:      mode_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign pop      = head_v_q && result.ready;
	assign adv      = item_v_s1 && (!skid_v_q || result.ready);
	assign in_ready = !item_v_s1 || adv;
	assign keys.ready = in_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_s1 <= 1'b0;
		end else if (in_ready) begin
			item_v_s1 <= keys.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && keys.valid) begin
			item_s1.column_pins_n <= keys.column_pins_n;
			item_s1.push_pin_n    <= keys.push_pin_n;
		end
	end

	// scan step
	assign pressed = ~item_s1.column_pins_n;
	assign sample  = {item_s1.column_pins_n, item_s1.push_pin_n};
	assign col     = col_code(pressed);
	assign cnt_inc = cnt_q + CNT_W'(1);

	always_comb begin
		phase_n       = phase_q;
		cnt_n         = cnt_q;
		ref_n         = ref_q;
		part_n        = part_q;
		res.row_drive = DRIVE_BOTH;
		res.scan_done = 1'b0;
		res.key_code  = CODE_NONE;
		res.key_mask  = '0;
		case (phase_q)
			PH_STABLE: begin
				res.row_drive = DRIVE_BOTH;
				if (sample != ref_q) begin
					res.scan_done = 1'b1;
				end else begin
					cnt_n = cnt_inc;
					if (cnt_inc >= stable_q) begin
						cnt_n   = '0;
						phase_n = PH_ROW1_SETTLE;
					end
				end
			end
			PH_ROW1_SETTLE: begin
				res.row_drive = DRIVE_ROW1;
				if (cnt_q >= settle_q) begin
					part_n = pressed;
					cnt_n  = '0;
					if (mode_q == MODE_SINGLE && col != 3'd0) begin
						res.scan_done = 1'b1;
						res.key_code  = {1'b0, col} + ROW1_OFFSET;
					end else begin
						phase_n = PH_ROW0_SETTLE;
					end
				end else begin
					cnt_n = cnt_inc;
				end
			end
			PH_ROW0_SETTLE: begin
				res.row_drive = DRIVE_ROW0;
				if (cnt_q >= settle_q) begin
					res.scan_done = 1'b1;
					if (mode_q == MODE_SINGLE) begin
						res.key_code = !item_s1.push_pin_n ? CODE_PUSH : {1'b0, col};
					end else begin
						res.key_mask = {~item_s1.push_pin_n, part_q, pressed};
					end
				end else begin
					cnt_n = cnt_inc;
				end
			end
			default: begin
				res.row_drive = DRIVE_BOTH;
				if (cnt_q >= settle_q) begin
					ref_n   = sample;
					cnt_n   = '0;
					phase_n = (stable_q == '0) ? PH_ROW1_SETTLE : PH_STABLE;
				end else begin
					cnt_n = cnt_inc;
				end
			end
		endcase
		if (res.scan_done) begin
			phase_n = PH_ALL_SETTLE;
			cnt_n   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ALL_SETTLE;
			cnt_q   <= '0;
			ref_q   <= '0;
			part_q  <= '0;
		end else if (adv) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			ref_q   <= ref_n;
			part_q  <= part_n;
		end
	end

	// two-entry result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_v_q) begin
					skid_v_q <= adv;
				end else begin
					head_v_q <= adv;
				end
			end else if (adv) begin
				if (!head_v_q) begin
					head_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				head_q <= skid_q;
				if (adv) begin
					skid_q <= res;
				end
			end else if (adv) begin
				head_q <= res;
			end
		end else if (adv) begin
			if (!head_v_q) begin
				head_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign result.valid     = head_v_q;
	assign result.row_drive = head_q.row_drive;
	assign result.scan_done = head_q.scan_done;
	assign result.key_code  = head_q.key_code;
	assign result.key_mask  = head_q.key_mask;

	// checks
	`KPS_ASSERT(a_skid_behind_head, clk, arst_n, skid_v_q |-> head_v_q)
	`KPS_ASSERT(a_idle_no_key, clk, arst_n,
		(result.valid && !result.scan_done) |-> (result.key_code == CODE_NONE && result.key_mask == '0))
	`KPS_ASSERT_NEVER(a_code_and_mask, clk, arst_n,
		result.valid && result.key_code != CODE_NONE && result.key_mask != '0)
	`KPS_ASSERT(a_row_scan_count, clk, arst_n,
		(adv && phase_q == PH_STABLE && !res.scan_done) |=> (cnt_q != '0 || phase_q == PH_ROW1_SETTLE))

endmodule
`default_nettype wire
